// ----- rtl/core/teq_pkg.sv -----
// Shared types and constants of the timer event queue.
package teq_pkg;
    localparam int MaxSlots  = 16;
    localparam int LinkW     = 5;
    localparam logic [LinkW-1:0] NoneLink = 5'd16;
    localparam logic [31:0] AllOnes = 32'hffffffff;

    localparam logic [2:0] ModeAlloc = 3'd0;
    localparam logic [2:0] ModeFree  = 3'd1;
    localparam logic [2:0] ModeRel   = 3'd2;
    localparam logic [2:0] ModeAbs   = 3'd3;
    localparam logic [2:0] ModeProc  = 3'd4;

    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StFull    = 3'd1;
    localparam logic [2:0] StBad     = 3'd2;
    localparam logic [2:0] StExpired = 3'd3;
    localparam logic [2:0] StDone    = 3'd4;

    // One classified command between front and back.
    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  slot;
        logic [31:0] periods;   // normalized expiry for schedule
        logic [31:0] ticks;
        logic [31:0] now_periods;
        logic [31:0] now_ticks;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_out;
        logic [31:0] periods;
        logic [31:0] ticks;
        logic        compare_load;
        logic        last;
    } res_t;
endpackage

// ----- rtl/core/teq_front.sv -----
// Front end: accepts transactions and normalizes relative times.
module teq_front
    import teq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] tick_range,
    input  logic        in_valid,
    output logic        in_stall,
    input  cmd_t        in_cmd,
    output logic        q_valid,
    input  logic        q_stall,
    output cmd_t        q_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_NORM, S_OUT} state_t;
    state_t state_reg;
    cmd_t   cmd_reg;
    cmd_t   acc_cmd;
    logic [32:0] span;
    logic [32:0] tsum;
    logic        need_norm;
    logic [31:0] qcnt_reg;
    logic [32:0] rem_reg;
    logic [5:0]  bit_reg;
    logic [33:0] trial;

    assign span = {1'b0, tick_range} + 33'd1;
    assign in_stall = (state_reg != S_IDLE);
    // hold valid off while the quotient is being applied
    assign q_valid = (state_reg == S_OUT) && (bit_reg != 6'h3f);
    assign q_cmd = cmd_reg;
    // restoring division step of ticks by span
    assign trial = {rem_reg, cmd_reg.ticks[bit_reg[4:0]]} - {1'b0, span};

    assign tsum = {1'b0, in_cmd.now_ticks} + {1'b0, in_cmd.ticks};
    assign need_norm = (in_cmd.mode == ModeRel) && (tsum[31:0] > tick_range);

    always_comb
    begin
        acc_cmd = in_cmd;
        if (in_cmd.mode == ModeRel)
        begin
            acc_cmd.ticks = tsum[31:0];
            acc_cmd.periods = in_cmd.now_periods + in_cmd.periods + {31'd0, tsum[32]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bit_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= acc_cmd;
                        if (need_norm)
                        begin
                            state_reg <= S_NORM;
                            bit_reg <= 6'd31;
                            rem_reg <= '0;
                            qcnt_reg <= '0;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_NORM:
                begin
                    if (!trial[33])
                    begin
                        rem_reg <= trial[32:0];
                        qcnt_reg[bit_reg[4:0]] <= 1'b1;
                    end
                    else
                        rem_reg <= {rem_reg[31:0], cmd_reg.ticks[bit_reg[4:0]]};
                    if (bit_reg == 6'd0)
                        state_reg <= S_OUT;
                    bit_reg <= bit_reg - 6'd1;
                end
                S_OUT:
                begin
                    if (bit_reg == 6'h3f)
                    begin
                        cmd_reg.periods <= cmd_reg.periods + qcnt_reg;
                        cmd_reg.ticks <= rem_reg[31:0];
                        bit_reg <= '0;
                    end
                    else if (!q_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/teq_back.sv -----
// Back end: slot table, sorted linked queue and result generation.
module teq_back
    import teq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    output logic q_stall,
    input  cmd_t q_cmd,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_res
);
    typedef enum logic [2:0] {S_IDLE, S_ALLOC, S_UNLINK, S_INS, S_PROC, S_RES} state_t;
    state_t state_reg;
    cmd_t   cmd_reg;
    logic [MaxSlots-1:0] used_reg;
    logic [31:0] ep_reg [MaxSlots];
    logic [31:0] et_reg [MaxSlots];
    logic [LinkW-1:0] nl_reg [MaxSlots];
    logic [LinkW-1:0] head_reg, old_head_reg, cur_reg;
    logic [LinkW-1:0] cnt_reg;
    res_t res_reg;
    logic rv_reg;
    logic [3:0] s;
    logic [3:0] c;
    logic [3:0] h;
    logic [3:0] nx;
    logic early_nx, early_h, exp_h;

    assign s = cmd_reg.slot;
    assign c = cur_reg[3:0];
    assign h = head_reg[3:0];
    assign nx = nl_reg[c][3:0];
    assign early_nx = cmd_reg.periods < ep_reg[nx] ||
        (cmd_reg.periods == ep_reg[nx] && cmd_reg.ticks < et_reg[nx]);
    assign early_h = cmd_reg.periods < ep_reg[h] ||
        (cmd_reg.periods == ep_reg[h] && cmd_reg.ticks < et_reg[h]);
    assign exp_h = cmd_reg.now_periods > ep_reg[h] ||
        (cmd_reg.now_periods == ep_reg[h] && cmd_reg.now_ticks >= et_reg[h]);

    assign q_stall = (state_reg != S_IDLE) || rv_reg;
    assign out_valid = rv_reg;
    assign out_res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            head_reg <= NoneLink;
            cnt_reg <= '0;
            rv_reg <= 1'b0;
            cur_reg <= '0;
            for (int i = 0; i < MaxSlots; i++)
            begin
                ep_reg[i] <= AllOnes;
                et_reg[i] <= AllOnes;
                nl_reg[i] <= NoneLink;
            end
        end
        else
        begin
            // process refills the result register itself
            if (rv_reg && !out_stall && state_reg != S_PROC)
                rv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && !rv_reg)
                    begin
                        cmd_reg <= q_cmd;
                        old_head_reg <= head_reg;
                        cur_reg <= (q_cmd.mode == ModeAlloc) ? '0 : head_reg;
                        if (q_cmd.mode == ModeAlloc)
                            state_reg <= S_ALLOC;
                        else if (q_cmd.mode == ModeFree || q_cmd.mode == ModeRel ||
                                 q_cmd.mode == ModeAbs)
                        begin
                            if (!used_reg[q_cmd.slot])
                            begin
                                res_reg <= '{StBad, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1};
                                rv_reg <= 1'b1;
                            end
                            else if (head_reg == {1'b0, q_cmd.slot})
                            begin
                                // unlink at head directly
                                head_reg <= nl_reg[q_cmd.slot];
                                nl_reg[q_cmd.slot] <= NoneLink;
                                state_reg <= S_RES;
                            end
                            else
                                state_reg <= S_UNLINK;
                        end
                        else if (q_cmd.mode == ModeProc)
                            state_reg <= S_PROC;
                        else
                        begin
                            res_reg <= '{StBad, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1};
                            rv_reg <= 1'b1;
                        end
                    end
                end
                S_ALLOC:
                begin
                    if (cnt_reg == LinkW'(MaxSlots))
                    begin
                        res_reg <= '{StFull, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1};
                        rv_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (!used_reg[c])
                    begin
                        used_reg[c] <= 1'b1;
                        ep_reg[c] <= AllOnes;
                        et_reg[c] <= AllOnes;
                        nl_reg[c] <= NoneLink;
                        cnt_reg <= cnt_reg + LinkW'(1);
                        res_reg <= '{StOk, c, 32'd0, 32'd0, 1'b0, 1'b1};
                        rv_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                        cur_reg <= cur_reg + LinkW'(1);
                end
                S_UNLINK:
                begin
                    // walk the list for the predecessor of the slot
                    if (cur_reg[4])
                    begin
                        nl_reg[s] <= NoneLink;
                        state_reg <= S_RES;
                    end
                    else if (nl_reg[c] == {1'b0, s})
                    begin
                        nl_reg[c] <= nl_reg[s];
                        nl_reg[s] <= NoneLink;
                        state_reg <= S_RES;
                    end
                    else
                        cur_reg <= nl_reg[c];
                end
                S_RES:
                begin
                    if (cmd_reg.mode == ModeFree)
                    begin
                        used_reg[s] <= 1'b0;
                        ep_reg[s] <= AllOnes;
                        et_reg[s] <= AllOnes;
                        cnt_reg <= cnt_reg - LinkW'(1);
                        if (!head_reg[4] && head_reg != old_head_reg)
                            res_reg <= '{StOk, s, ep_reg[h], et_reg[h], 1'b1, 1'b1};
                        else
                            res_reg <= '{StOk, s, 32'd0, 32'd0, 1'b0, 1'b1};
                        rv_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        ep_reg[s] <= cmd_reg.periods;
                        et_reg[s] <= cmd_reg.ticks;
                        if (head_reg[4] || early_h)
                        begin
                            nl_reg[s] <= head_reg;
                            head_reg <= {1'b0, s};
                            res_reg <= '{StOk, s, cmd_reg.periods, cmd_reg.ticks,
                                         1'b1, 1'b1};
                            rv_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            cur_reg <= head_reg;
                            state_reg <= S_INS;
                        end
                    end
                end
                S_INS:
                begin
                    if (nl_reg[c][4] || early_nx)
                    begin
                        nl_reg[s] <= nl_reg[c];
                        nl_reg[c] <= {1'b0, s};
                        if (head_reg != old_head_reg)
                            res_reg <= '{StOk, s, ep_reg[h], et_reg[h], 1'b1, 1'b1};
                        else
                            res_reg <= '{StOk, s, cmd_reg.periods, cmd_reg.ticks,
                                         1'b0, 1'b1};
                        rv_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                        cur_reg <= nl_reg[c];
                end
                S_PROC:
                begin
                    if (!rv_reg || !out_stall)
                    begin
                        rv_reg <= 1'b1;
                        if (!head_reg[4] && exp_h)
                        begin
                            res_reg <= '{StExpired, h, ep_reg[h], et_reg[h], 1'b0, 1'b0};
                            head_reg <= nl_reg[h];
                            nl_reg[h] <= NoneLink;
                            ep_reg[h] <= '0;
                            et_reg[h] <= '0;
                        end
                        else
                        begin
                            if (!head_reg[4])
                                res_reg <= '{StDone, 4'd0, ep_reg[h], et_reg[h], 1'b1, 1'b1};
                            else
                                res_reg <= '{StDone, 4'd0, 32'd0, 32'd0, 1'b0, 1'b1};
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/core/timer_event_queue_core.sv -----
// Top level of the sorted timer event queue.
// Each transaction is normalized in the front end (a relative time whose ticks, added to
// now_ticks, exceed tick_range takes a bit-serial division and then a step to apply it),
// queued one deep, then executed by the back end: allocate scans up to 16 slots, free
// walks the linked list once to unlink and schedule walks it once to unlink and once to
// insert, and process gives one result per cycle per expired head while the output is
// not stalled, plus a final done result.
module timer_event_queue_core
    import teq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [3:0]  slot,
    input  logic [31:0] time_periods,
    input  logic [31:0] time_ticks,
    input  logic [31:0] now_periods,
    input  logic [31:0] now_ticks,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [3:0]  slot_out,
    output logic [31:0] out_periods,
    output logic [31:0] out_ticks,
    output logic        compare_load,
    output logic        last
);
    logic [31:0] tick_range_reg;
    cmd_t in_cmd, q_cmd;
    logic q_valid, q_stall;
    res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_range_reg <= AllOnes;
        else if (cfg_we)
            tick_range_reg <= cfg_wdata;
    end

    assign in_cmd = '{mode, slot, time_periods, time_ticks, now_periods, now_ticks};

    teq_front u_front (
        .clk(clk), .rst_n(rst_n), .tick_range(tick_range_reg),
        .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_stall(q_stall), .q_cmd(q_cmd)
    );

    teq_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_stall(q_stall),
        .q_cmd(q_cmd), .out_valid(out_valid), .out_stall(out_stall), .out_res(res)
    );

    assign status = res.status;
    assign slot_out = res.slot_out;
    assign out_periods = res.periods;
    assign out_ticks = res.ticks;
    assign compare_load = res.compare_load;
    assign last = res.last;
endmodule
